>>> hdl/wsl_pkg.sv
package wsl_pkg;

  // Pattern register geometry: two 64-bit words of eight bytes each
  localparam int PAT_REG_BYTES = 16;
  localparam int MAX_PATTERN_BYTES_DEF = 16;

  localparam logic [7:0] BYTE_NL = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'h21;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;
  localparam logic [15:0] COL_MAX = 16'hFFFF;

  typedef logic [PAT_REG_BYTES-1:0][7:0] pat_bytes_t;

  typedef enum logic [1:0] {
    REG_PAT_LEN = 2'd0,
    REG_PAT_LO  = 2'd1,
    REG_PAT_HI  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] match_line;
    logic [15:0] match_column;
  } out_item_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

>>> hdl/wsl_cell.sv
module wsl_cell import wsl_pkg::*; #(
  parameter int K = 0,
  parameter int LEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [7:0]       in_byte,
  input  logic             in_valid,
  input  logic [LEN_W-1:0] eff_len,
  input  pat_bytes_t       pat,
  output logic [7:0]       byte_r,
  output logic             valid_r,
  output logic             ok
);

  logic [7:0]       byte_nxt;
  logic             valid_nxt;
  logic [LEN_W-1:0] pat_idx;
  logic [7:0]       pat_byte;

  // cell K holds the word byte of age K; it lines up with pattern byte len-1-K
  assign pat_idx  = eff_len - LEN_W'(K + 1);
  assign pat_byte = (pat_idx < LEN_W'(PAT_REG_BYTES)) ? pat[pat_idx[3:0]] : 8'h00;

  // judged on the window after this shift
  assign ok = (LEN_W'(K) >= eff_len) || (in_valid && (in_byte == pat_byte));

  always_comb begin
    byte_nxt  = ctl.shift ? in_byte : byte_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> hdl/wsl_out_buf.sv
module wsl_out_buf import wsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // push never arrives while the skid slot is taken (full stalls the input)
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop || !main_valid_r) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid slot holds a result while the output slot is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(main_valid_r && out_stall))
    else $error("skid slot filled although the output slot could drain");

endmodule

>>> hdl/word_substring_locator.sv
// Channel | Handshake                       | Payload
// in      | in_valid / in_stall             | in_data   (in_item_t: text_byte, last_byte)
// out     | out_valid / out_stall           | out_data  (out_item_t: status, line, column)
// cfg     | cfg_valid / cfg_ready (always 1)| cfg_index, cfg_data (64 bit)
//
// One text byte per clock while in_stall is low; each transfer is judged in the cycle it is taken,
// against the whole pattern at once across the cell row.
// A result is registered in the output slot, or in the skid slot while out_stall holds it, before out_valid.
// Synchronous active-low reset clears the cell flags and pattern and sets the position to line 1, column 1.
// in_stall rises only when both output slots hold results (out side stalled).
module word_substring_locator import wsl_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  reg_idx_t  cfg_index,
  input  logic [63:0] cfg_data
);

  // length bus wide enough for both the 5-bit register and the cell count
  localparam int LEN_W = ($clog2(MAX_PATTERN_BYTES + 1) > 5) ?
                         $clog2(MAX_PATTERN_BYTES + 1) : 5;

  // --- configuration -------------------------------------------------------
  logic [4:0]  pat_len_r, pat_len_nxt;
  logic [63:0] pat_lo_r, pat_lo_nxt;
  logic [63:0] pat_hi_r, pat_hi_nxt;
  pat_bytes_t  pat;
  logic [LEN_W-1:0] len_ext;
  logic [LEN_W-1:0] eff_len;

  assign cfg_ready = 1'b1;

  always_comb begin
    pat_len_nxt = pat_len_r;
    pat_lo_nxt  = pat_lo_r;
    pat_hi_nxt  = pat_hi_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAT_LEN: pat_len_nxt = cfg_data[4:0];
        REG_PAT_LO:  pat_lo_nxt  = cfg_data;
        REG_PAT_HI:  pat_hi_nxt  = cfg_data;
        default:     ;  // unmapped index: write ignored
      endcase
    end
  end

  assign pat     = {pat_hi_r, pat_lo_r};  // byte 0 sits in bits 7:0
  assign len_ext = LEN_W'(pat_len_r);
  assign eff_len = (len_ext > LEN_W'(MAX_PATTERN_BYTES)) ?
                   LEN_W'(MAX_PATTERN_BYTES) : len_ext;

  // --- input decode --------------------------------------------------------
  logic      acc;
  logic      printable;
  cell_ctl_t ctl;

  assign acc       = in_valid && !in_stall;
  assign printable = (in_data.text_byte >= PRINT_LO) && (in_data.text_byte <= PRINT_HI);
  assign ctl.shift = acc && printable;
  // any non-word byte ends the word; the last byte wipes the text state
  assign ctl.clear = acc && (!printable || in_data.last_byte);

  // --- cell row: cell 0 takes the newest byte, each hands its byte on ------
  logic [MAX_PATTERN_BYTES-1:0][7:0] cell_byte;
  logic [MAX_PATTERN_BYTES-1:0]      cell_valid;
  logic [MAX_PATTERN_BYTES-1:0]      cell_ok;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      wsl_cell #(.K(k), .LEN_W(LEN_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_byte  (in_data.text_byte),
        .in_valid (1'b1),
        .eff_len  (eff_len),
        .pat      (pat),
        .byte_r   (cell_byte[k]),
        .valid_r  (cell_valid[k]),
        .ok       (cell_ok[k])
      );
    end else begin : g_body
      wsl_cell #(.K(k), .LEN_W(LEN_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_byte  (cell_byte[k-1]),
        .in_valid (cell_valid[k-1]),
        .eff_len  (eff_len),
        .pat      (pat),
        .byte_r   (cell_byte[k]),
        .valid_r  (cell_valid[k]),
        .ok       (cell_ok[k])
      );
    end
  end

  // --- position and match bookkeeping --------------------------------------
  logic [23:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic        reported_r, reported_nxt;
  logic        found;
  logic        push;
  out_item_t   push_data;
  logic [15:0] match_col;

  // a match needs a word at least len long; cell valid flags cover that
  assign found = ctl.shift && !reported_r && (eff_len != '0) && (&cell_ok);

  // start column of the match; pinned once the column has saturated
  assign match_col = (col_r >= COL_MAX) ? COL_MAX :
                     (col_r - 16'(eff_len - LEN_W'(1)));

  always_comb begin
    push_data.status       = ST_FOUND;
    push_data.match_line   = line_r;
    push_data.match_column = match_col;
    push                   = found;
    if (acc && in_data.last_byte && !found && !reported_r) begin
      push                   = 1'b1;
      push_data.status       = (eff_len == '0) ? ST_EMPTY : ST_NOT_FOUND;
      push_data.match_line   = '0;
      push_data.match_column = '0;
    end
  end

  always_comb begin
    line_nxt     = line_r;
    col_nxt      = col_r;
    reported_nxt = reported_r;
    if (acc) begin
      if (in_data.last_byte) begin
        line_nxt     = 24'd1;
        col_nxt      = 16'd1;
        reported_nxt = 1'b0;
      end else begin
        if (found) begin
          reported_nxt = 1'b1;
        end
        if (in_data.text_byte == BYTE_NL) begin
          if (line_r < LINE_MAX) begin
            line_nxt = line_r + 24'd1;
          end
          col_nxt = 16'd1;
        end else if (col_r < COL_MAX) begin
          col_nxt = col_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
      line_r     <= 24'd1;
      col_r      <= 16'd1;
      reported_r <= 1'b0;
    end else begin
      pat_len_r  <= pat_len_nxt;
      pat_lo_r   <= pat_lo_nxt;
      pat_hi_r   <= pat_hi_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      reported_r <= reported_nxt;
    end
  end

  // --- output register with skid slot ---------------------------------------
  wsl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_single_found: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> !reported_r)
    else $error("second found result within one text");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.last_byte) |=> (!reported_r && line_r == 24'd1 && col_r == 16'd1
                                    && cell_valid == '0))
    else $error("text state not cleared after the last byte");

  a_position_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != 24'd0) && (col_r != 16'd0))
    else $error("line or column dropped to zero");

endmodule

>>> test/word_substring_locator_checker.sv
module word_substring_locator_checker import wsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          reports_due
);

  localparam int WINDOW = MAX_PATTERN_BYTES_DEF;

  // register copy
  logic [4:0] pat_len;
  pat_bytes_t pat;

  // per-text scan state; recent[0] is the newest word byte
  logic [WINDOW-1:0][7:0] recent;
  logic [4:0]             run_len;
  logic [23:0]            line_no;
  logic [15:0]            col_no;
  logic                   found_already;

  out_item_t predicted_reports[$];
  int        fail_count = 0;

  task automatic restart_text();
    recent        = '0;
    run_len       = '0;
    line_no       = 24'd1;
    col_no        = 16'd1;
    found_already = 1'b0;
  endtask

  task automatic scan_text_byte(input in_item_t item);
    int        eff_len;
    logic      hit;
    logic      have_rpt;
    out_item_t rpt;
    eff_len  = (pat_len > WINDOW) ? WINDOW : int'(pat_len);
    have_rpt = 1'b0;
    rpt      = '0;
    if (item.text_byte >= PRINT_LO && item.text_byte <= PRINT_HI) begin
      recent = {recent[WINDOW-2:0], item.text_byte};
      if (run_len < WINDOW) run_len++;
      if (!found_already && eff_len > 0 && run_len >= eff_len) begin
        hit = 1'b1;
        for (int i = 0; i < eff_len; i++)
          if (recent[eff_len-1-i] != pat[i]) hit = 1'b0;
        if (hit) begin
          rpt.status       = ST_FOUND;
          rpt.match_line   = line_no;
          rpt.match_column = (col_no >= COL_MAX) ? COL_MAX : col_no - 16'(eff_len - 1);
          found_already    = 1'b1;
          have_rpt         = 1'b1;
        end
      end
    end else begin
      run_len = '0;
    end

    if (item.text_byte == BYTE_NL) begin
      if (line_no < LINE_MAX) line_no++;
      col_no = 16'd1;
    end else if (col_no < COL_MAX) begin
      col_no++;
    end

    if (item.last_byte) begin
      if (!have_rpt && !found_already) begin
        rpt.status = (eff_len == 0) ? ST_EMPTY : ST_NOT_FOUND;
        have_rpt   = 1'b1;
      end
      restart_text();
    end
    if (have_rpt) predicted_reports.push_back(rpt);
  endtask

  function automatic int field_diff(string field, logic [23:0] want, logic [23:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      pat_len = '0;
      pat     = '0;
      restart_text();
      predicted_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          REG_PAT_LEN: pat_len = cfg_data[4:0];
          REG_PAT_LO:  pat[7:0] = cfg_data;
          REG_PAT_HI:  pat[15:8] = cfg_data;
          default: ;
        endcase
      // input first, so a prediction is queued before the matching result is checked
      if (in_valid && !in_stall) scan_text_byte(in_data);
      if (out_valid && !out_stall) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none got status %0d line %0d column %0d",
                   $time, out_data.status, out_data.match_line, out_data.match_column);
          fail_count++;
        end else begin
          want = predicted_reports.pop_front();
          fail_count += field_diff("status", 24'(want.status), 24'(out_data.status));
          fail_count += field_diff("match_line", want.match_line, out_data.match_line);
          fail_count += field_diff("match_column", 24'(want.match_column),
                                   24'(out_data.match_column));
        end
      end
    end
    mismatches  <= fail_count;
    reports_due <= predicted_reports.size();
  end

endmodule

>>> test/word_substring_locator_test.sv
module word_substring_locator_test;
  import wsl_pkg::*;

  // no transfer on any channel for this long means the block has hung
  localparam int WATCHDOG_LIMIT  = 5000;
  // the deliberate output hold-off, long enough to fill both result slots
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 98;

  typedef enum int {FLOW, LIGHT, HEAVY, PERIODIC} stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_PAT_LEN;
  logic [63:0] cfg_data  = '0;

  int mismatches;
  int reports_due;
  int idle_cycles  = 0;
  bit hold_off_due = 1'b0;

  // what the stimulus believes is programmed; used only to shape the texts
  logic [4:0]  text_pat_len = '0;
  pat_bytes_t  text_pattern = '0;
  logic [7:0]  text[$];
  int          burst_left = 0;
  int          sent_items = 0;

  word_substring_locator dut (.*);

  word_substring_locator_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: restarts on every transfer, config writes included.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: segments of random length, each with its own stall behaviour.
  // A hold-off request from the stimulus side is served here and counted here,
  // while the sender keeps offering bytes, so the result slots fill and the
  // block has to push back on its input.
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    int          tick;
    tick = 0;
    wait (rst_n);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 60);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_off_due) begin
          hold_off_due = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          out_stall <= 1'b0;
        end else begin
          case (mode)
            FLOW:    out_stall <= 1'b0;
            LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
            HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (tick % 3 == 0);
          endcase
        end
      end
    end
  end

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  // anything that ends a word: space, newline, controls, DEL, upper half
  function automatic logic [7:0] rand_break();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1, 2:    return BYTE_NL;
      3:       return 8'($urandom_range(0, 32));
      4:       return 8'h7F;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // One byte per call. The sender runs in bursts; between bursts valid is dropped
  // for a gap, so valid is never dropped and raised in the same step.
  task automatic put_byte(input logic [7:0] b, input logic closes);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{text_byte: b, last_byte: closes};
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic send_text(input logic closes);
    for (int i = 0; i < text.size(); i++)
      put_byte(text[i], closes && (i == text.size() - 1));
    text.delete();
  endtask

  // Wait until every predicted result has been taken, plus a margin for a
  // byte that is still in flight but produces nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_pattern(input logic [63:0] len_word, input logic [63:0] lo,
                               input logic [63:0] hi);
    write_reg(REG_PAT_LEN, len_word);
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    cfg_valid    <= 1'b0;
    text_pat_len = len_word[4:0];
    text_pattern = {hi, lo};
  endtask

  // First phases hit the register extremes, the rest are mostly printable
  // patterns of favoured short lengths, with the odd empty, oversized,
  // unmatchable or fully random one.
  task automatic configure_phase(input int ph);
    pat_bytes_t  pb;
    logic [63:0] len_word;
    int          len;
    for (int k = 0; k < PAT_REG_BYTES; k++) pb[k] = rand_printable();
    len_word = {$urandom, $urandom};
    len      = $urandom_range(1, $urandom_range(1, 16));
    case (ph)
      0: begin
        // all ones: length 31 (read as 16) of 0xFF, which can never match
        len_word = '1;
        pb       = '1;
      end
      1: begin
        len_word = '0;
        pb       = '0;
      end
      2: len_word[4:0] = 5'd1;
      3: len_word[4:0] = 5'd16;
      4: len_word[4:0] = 5'($urandom_range(17, 31));
      default: begin
        case ($urandom_range(0, 9))
          0: len_word[4:0] = 5'd0;
          1: begin
            pb = {$urandom, $urandom, $urandom, $urandom};
            len_word[4:0] = 5'($urandom_range(0, 31));
          end
          2: begin
            // unmatchable: a byte outside the printable range
            pb[$urandom_range(0, len - 1)] = rand_break();
            len_word[4:0] = 5'(len);
          end
          default: len_word[4:0] = 5'(len);
        endcase
      end
    endcase
    write_pattern(len_word, pb[7:0], pb[15:8]);
  endtask

  task automatic add_word();
    int plen;
    int cut;
    plen = (text_pat_len > 16) ? 16 : int'(text_pat_len);
    case ($urandom_range(0, 5))
      0, 1: begin
        // whole pattern, possibly with printable bytes either side
        repeat ($urandom_range(0, 3)) text.push_back(rand_printable());
        for (int k = 0; k < plen; k++) text.push_back(text_pattern[k]);
        repeat ($urandom_range(0, 3)) text.push_back(rand_printable());
      end
      2: begin
        // pattern, split by a word break when the cut falls inside it
        cut = $urandom_range(0, plen);
        for (int k = 0; k < plen; k++) begin
          if (k == cut) text.push_back(rand_break());
          text.push_back(text_pattern[k]);
        end
      end
      3: begin
        // near miss: one byte altered
        cut = (plen > 0) ? $urandom_range(0, plen - 1) : 0;
        for (int k = 0; k < plen; k++)
          text.push_back((k == cut) ? rand_printable() : text_pattern[k]);
      end
      4: repeat ($urandom_range(1, 20)) text.push_back(rand_printable());
      default: repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    endcase
    text.push_back(rand_break());
  endtask

  task automatic build_text();
    if ($urandom_range(0, 9) == 0) begin
      text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) add_word();
      // often end on a word byte so a match can land on the final byte
      if (text.size() > 1 && $urandom_range(0, 1) == 0) void'(text.pop_back());
    end
  endtask

  initial begin : stimulus
    int goal;
    int texts_done;
    texts_done = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pattern straight after reset, 0xFF as a text's first byte
    text = {8'h41};
    send_text(1'b1);
    text = {8'hFF, 8'h00};
    send_text(1'b1);
    settle();

    // printable boundaries; match on the final byte, on line 2
    write_pattern(64'd3, 64'h7E217E, 64'd0);
    text = {BYTE_NL, 8'h20, 8'h7E, 8'h21, 8'h7E};
    send_text(1'b1);
    // DEL breaks the word; after the first hit nothing more until the end
    text = {8'h7E, 8'h21, 8'h7F, 8'h7E, 8'h21, 8'h7E, 8'h7E, 8'h21, 8'h7E, 8'h41};
    send_text(1'b1);
    settle();

    // pattern holding a non-printable byte is never found
    write_pattern(64'd2, 64'h8041, 64'd0);
    text = {8'h41, 8'h80, 8'h41};
    send_text(1'b1);
    settle();

    // Random phases. A phase may stop part-way through a text, so the next
    // setting takes over a half-scanned text.
    for (int ph = 0; ph < PHASES; ph++) begin
      configure_phase(ph);
      goal = sent_items + ITEMS_PER_PHASE;
      while (sent_items < goal) begin
        build_text();
        send_text(1'b1);
        texts_done++;
        if (texts_done == 40 || texts_done == 120) hold_off_due = 1'b1;
      end
      if ($urandom_range(0, 2) == 0) begin
        add_word();
        send_text(1'b0);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
